// File: sv/dcrc_pkg.sv
// shared types, constants and the crc helper for the dual copy record checker
`default_nettype none
package dcrc_pkg;

  localparam int DATA_BYTES = 64;
  localparam int HDR_BYTES  = 12;
  localparam int CRC_SPAN   = DATA_BYTES + HDR_BYTES;
  localparam int REC_BYTES  = CRC_SPAN + 4;
  localparam int POS_W      = $clog2(REC_BYTES + 1);

  localparam logic [POS_W-1:0] CRC_POS = POS_W'(CRC_SPAN);
  localparam logic [POS_W-1:0] REC_POS = POS_W'(REC_BYTES);
  localparam logic [15:0]      DATA_LEN = 16'(DATA_BYTES);

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [1:0] {
    OP_COPY_A = 2'd0,
    OP_COPY_B = 2'd1,
    OP_NEW    = 2'd2,
    OP_RSVD   = 2'd3
  } op_t;

  typedef enum logic {
    KIND_VERDICT = 1'b0,
    KIND_CRC     = 1'b1
  } kind_t;

  typedef enum logic {
    REG_MAGIC   = 1'b0,
    REG_VERSION = 1'b1
  } reg_idx_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
    logic       last;
    logic       read_failed;
  } item_t;

  typedef struct packed {
    kind_t       kind;
    logic        copy_a_valid;
    logic        copy_b_valid;
    logic        load_ok;
    logic        load_copy;
    logic        save_target;
    logic [31:0] next_counter;
    logic [31:0] crc_value;
  } res_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: sv/dual_copy_record_checker.sv
// top level: stream ports, configuration registers, front, queue and back end
// the final byte passes the front register and the queue, then the result register
// throughput: one byte per cycle while results are taken; the byte-wide crc step
// in the back end sets the rate; a four-entry queue decouples input from result stalls
// reset (rst, synchronous): clears the queue, stream state, copy a verdict and both
// configuration registers; no clearing pass, the block accepts bytes right after reset
`default_nettype none
module dual_copy_record_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  // slave stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [7:0] data_byte, [8] read_failed
  input  wire logic [1:0]  s_tuser,   // [1:0] operation
  input  wire logic        s_tlast,   // byte_last
  // master stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [71:0]      m_tdata,   // [0] copy_a_valid, [1] copy_b_valid, [2] load_ok,
                                      // [3] load_copy, [4] save_target,
                                      // [36:5] next_counter, [68:37] crc_value
  output logic             m_tuser,   // result_kind
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import dcrc_pkg::*;

  logic [31:0] expected_magic;
  logic [15:0] expected_version;
  item_t       in_item;
  logic        push;
  item_t       push_item;
  logic        q_full;
  logic        q_valid;
  item_t       q_item;
  logic        pop;
  res_t        res;
  reg_idx_t    reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic   <= '0;
      expected_version <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_MAGIC:   expected_magic   <= pwdata;
        REG_VERSION: expected_version <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MAGIC:   prdata = expected_magic;
      REG_VERSION: prdata = {16'd0, expected_version};
      default:     prdata = '0;
    endcase
  end

  assign in_item.op          = op_t'(s_tuser);
  assign in_item.data_byte   = s_tdata[7:0];
  assign in_item.last        = s_tlast;
  assign in_item.read_failed = s_tdata[8];

  dcrc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (in_item),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  dcrc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  dcrc_back u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .pop              (pop),
    .expected_magic   (expected_magic),
    .expected_version (expected_version),
    .res_valid        (m_tvalid),
    .res              (res),
    .res_ready        (m_tready)
  );

  assign m_tuser = res.kind;
  assign m_tdata = {3'd0, res.crc_value, res.next_counter, res.save_target,
                    res.load_copy, res.load_ok, res.copy_b_valid, res.copy_a_valid};

endmodule
`default_nettype wire

// File: sv/dcrc_front.sv
// front stage: takes input requests, drops unused operation codes, feeds the queue
`default_nettype none
module dcrc_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire dcrc_pkg::item_t in_item,
  output logic                 push,
  output dcrc_pkg::item_t      push_item,
  input  wire logic            q_full
);
  import dcrc_pkg::*;

  logic  f_valid;
  item_t f_item;

  assign in_ready  = !f_valid || !q_full;
  assign push      = f_valid;
  assign push_item = f_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      // unused code is swallowed here and never reaches the back end
      f_valid <= (in_item.op != OP_RSVD);
    end else if (!q_full) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      f_item <= in_item;
    end
  end

endmodule
`default_nettype wire

// File: sv/dcrc_queue.sv
// short queue between front and back
`default_nettype none
module dcrc_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire dcrc_pkg::item_t push_item,
  output logic                 full,
  output logic                 q_valid,
  output dcrc_pkg::item_t      q_item,
  input  wire logic            pop
);
  import dcrc_pkg::*;

  item_t            entries [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr;
  logic [Q_AW-1:0]  rd_ptr;
  logic [Q_AW:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == (Q_AW+1)'(Q_DEPTH));
  assign q_valid = (count != '0);
  assign q_item  = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= (Q_AW+1)'(Q_DEPTH))
    else $error("queue count beyond depth");

  a_ptr_track: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == (Q_AW+1)'(Q_DEPTH)) |-> (wr_ptr == rd_ptr))
    else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

// File: sv/dcrc_back.sv
// back end: crc, header capture, copy verdicts and the result register
`default_nettype none
module dcrc_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire dcrc_pkg::item_t q_item,
  output logic                 pop,
  input  wire logic [31:0]     expected_magic,
  input  wire logic [15:0]     expected_version,
  output logic                 res_valid,
  output dcrc_pkg::res_t       res,
  input  wire logic            res_ready
);
  import dcrc_pkg::*;

  // stream state
  logic [31:0]      crc;
  logic [POS_W-1:0] pos;
  logic [31:0]      cap_magic;
  logic [15:0]      cap_version;
  logic [15:0]      cap_length;
  logic [31:0]      cap_counter;
  logic [31:0]      cap_crc;
  logic             rerr_seen;
  // held copy a verdict
  logic             copy_a_ok;
  logic [31:0]      copy_a_seq;

  logic [31:0]      crc_next;
  logic [POS_W-1:0] pos_next;
  logic [31:0]      magic_next;
  logic [15:0]      version_next;
  logic [15:0]      length_next;
  logic [31:0]      counter_next;
  logic [31:0]      stored_next;
  logic             rerr_next;
  logic [31:0]      ver_word;
  logic [31:0]      len_word;
  logic [POS_W-1:0] crc_off;
  logic             stream_ok;
  logic             makes_result;
  logic             go;
  logic             va;
  logic             vb;
  logic             b_newer;
  logic             a_newer;
  logic [31:0]      newest;
  res_t             res_next;

  function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] idx,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = w;
    r[idx*8 +: 8] = b;
    return r;
  endfunction

  always_comb begin
    crc_next     = crc;
    magic_next   = cap_magic;
    version_next = cap_version;
    length_next  = cap_length;
    counter_next = cap_counter;
    stored_next  = cap_crc;
    crc_off      = pos - CRC_POS;
    ver_word     = put_byte({16'd0, cap_version}, pos[1:0], q_item.data_byte);
    len_word     = put_byte({16'd0, cap_length}, 2'(pos - POS_W'(6)), q_item.data_byte);
    rerr_next    = rerr_seen || q_item.read_failed;
    pos_next     = (pos < REC_POS) ? pos + 1'b1 : pos;

    if (pos < CRC_POS) begin
      crc_next = crc_byte(crc, q_item.data_byte);
    end
    if (pos < POS_W'(4)) begin
      magic_next = put_byte(cap_magic, pos[1:0], q_item.data_byte);
    end else if (pos < POS_W'(6)) begin
      version_next = ver_word[15:0];
    end else if (pos < POS_W'(8)) begin
      length_next = len_word[15:0];
    end else if (pos < POS_W'(HDR_BYTES)) begin
      counter_next = put_byte(cap_counter, pos[1:0], q_item.data_byte);
    end else if (pos >= CRC_POS && pos < REC_POS) begin
      stored_next = put_byte(cap_crc, crc_off[1:0], q_item.data_byte);
    end

    stream_ok = !rerr_next && (pos_next == REC_POS) &&
                (magic_next == expected_magic) && (version_next == expected_version) &&
                (length_next == DATA_LEN) && (stored_next == crc_next);
  end

  // verdict on copy b's final byte
  always_comb begin
    va      = copy_a_ok;
    vb      = stream_ok;
    b_newer = counter_next > copy_a_seq;
    a_newer = copy_a_seq > counter_next;
    if (va && vb) begin
      newest = b_newer ? counter_next : copy_a_seq;
    end else if (va) begin
      newest = copy_a_seq;
    end else if (vb) begin
      newest = counter_next;
    end else begin
      newest = '0;
    end

    res_next = '0;
    if (q_item.op == OP_COPY_B) begin
      res_next.kind         = KIND_VERDICT;
      res_next.copy_a_valid = va;
      res_next.copy_b_valid = vb;
      res_next.load_ok      = va || vb;
      res_next.load_copy    = vb && (!va || b_newer);
      res_next.save_target  = va && (!vb || a_newer);
      res_next.next_counter = newest + 32'd1;
    end else begin
      res_next.kind      = KIND_CRC;
      res_next.crc_value = crc_next;
    end
  end

  assign makes_result = q_item.last && (q_item.op != OP_COPY_A);
  assign go           = q_valid && (!makes_result || !res_valid || res_ready);
  assign pop          = go;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc         <= CRC_INIT;
      pos         <= '0;
      cap_magic   <= '0;
      cap_version <= '0;
      cap_length  <= '0;
      cap_counter <= '0;
      cap_crc     <= '0;
      rerr_seen   <= 1'b0;
      copy_a_ok   <= 1'b0;
      copy_a_seq  <= '0;
      res_valid   <= 1'b0;
    end else begin
      if (go && makes_result) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (go) begin
        if (q_item.last) begin
          crc         <= CRC_INIT;
          pos         <= '0;
          cap_magic   <= '0;
          cap_version <= '0;
          cap_length  <= '0;
          cap_counter <= '0;
          cap_crc     <= '0;
          rerr_seen   <= 1'b0;
          if (q_item.op == OP_COPY_A) begin
            copy_a_ok  <= stream_ok;
            copy_a_seq <= counter_next;
          end
        end else begin
          crc         <= crc_next;
          pos         <= pos_next;
          cap_magic   <= magic_next;
          cap_version <= version_next;
          cap_length  <= length_next;
          cap_counter <= counter_next;
          cap_crc     <= stored_next;
          rerr_seen   <= rerr_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && makes_result) begin
      res <= res_next;
    end
  end

  a_pos_sat: assert property (@(posedge clk) disable iff (rst)
    pos <= REC_POS)
    else $error("byte position beyond record size");

  a_stream_clear: assert property (@(posedge clk) disable iff (rst)
    (go && q_item.last) |=> (pos == '0 && crc == CRC_INIT && !rerr_seen))
    else $error("stream state not cleared after final byte");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (go && makes_result) |-> (!res_valid || res_ready))
    else $error("pending result overwritten");

  a_kind_match: assert property (@(posedge clk) disable iff (rst)
    (go && makes_result && q_item.op == OP_NEW) |=> (res.kind == KIND_CRC))
    else $error("new record result has wrong kind");

endmodule
`default_nettype wire

// File: dv/dual_copy_record_checker_test.sv
// testbench for the dual copy record checker: directed and random byte streams, checked results
`timescale 1ns / 1ps
module dual_copy_record_checker_test;
  import dcrc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 160;
  localparam int PHASE_BYTES    = 50;
  localparam int HOLD_CYCLES    = 80;

  typedef enum int {
    FLAW_NONE,
    FLAW_MAGIC,
    FLAW_VERSION,
    FLAW_LENGTH,
    FLAW_CRC,
    FLAW_READ,
    FLAW_SHORT,
    FLAW_LONG,
    FLAW_MIXED_OPS
  } flaw_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;    // [7:0] data_byte, [8] read_failed
  logic [1:0]  s_tuser = '0;    // [1:0] operation
  logic        s_tlast = 1'b0;  // byte_last
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;         // [0] copy_a_valid, [1] copy_b_valid, [2] load_ok,
                                // [3] load_copy, [4] save_target,
                                // [36:5] next_counter, [68:37] crc_value
  logic        m_tuser;         // result_kind
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  dual_copy_record_checker dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // shadow of the block: configuration, stream state and held copy a verdict
  logic [31:0] want_magic;
  logic [15:0] want_version;
  logic [31:0] run_crc;
  int unsigned run_pos;
  logic [31:0] hdr_magic;
  logic [15:0] hdr_version;
  logic [15:0] hdr_length;
  logic [31:0] hdr_counter;
  logic [31:0] hdr_stored_crc;
  bit          run_rerr;
  bit          held_a_ok;
  logic [31:0] held_a_seq;
  res_t        due_outcomes[$];

  int error_count;
  int bytes_accepted;
  int results_checked;
  int verdicts_checked;
  int settings_used;
  int idle_cycles;
  bit tx_smooth;
  bit rx_smooth;
  bit rx_hold_tog;
  bit rx_hold_seen;
  int rx_left;

  function automatic logic [31:0] crc_next(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    repeat (8) c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    return c;
  endfunction

  function automatic void clear_run();
    run_crc = CRC_INIT;
    run_pos = 0;
    hdr_magic = '0;
    hdr_version = '0;
    hdr_length = '0;
    hdr_counter = '0;
    hdr_stored_crc = '0;
    run_rerr = 1'b0;
  endfunction

  // advances the shadow by one accepted byte and queues the result it causes
  function automatic void scan_byte(op_t op, logic [7:0] b, bit last, bit rerr);
    int unsigned p;
    bit          good;
    logic [31:0] newest;
    res_t        r;
    p = run_pos;
    if (op == OP_RSVD) return;
    if (rerr) run_rerr = 1'b1;
    if (p < CRC_SPAN) run_crc = crc_next(run_crc, b);
    if (p < 4) hdr_magic[8*p +: 8] = b;
    else if (p < 6) hdr_version[8*(p-4) +: 8] = b;
    else if (p < 8) hdr_length[8*(p-6) +: 8] = b;
    else if (p < 12) hdr_counter[8*(p-8) +: 8] = b;
    else if (p >= CRC_SPAN && p < REC_BYTES) hdr_stored_crc[8*(p-CRC_SPAN) +: 8] = b;
    if (p < REC_BYTES) run_pos = p + 1;
    if (!last) return;
    good = !run_rerr && run_pos == REC_BYTES && hdr_magic == want_magic &&
           hdr_version == want_version && hdr_length == DATA_LEN && hdr_stored_crc == run_crc;
    r = '0;
    newest = '0;
    case (op)
      OP_COPY_A: begin
        held_a_ok = good;
        held_a_seq = hdr_counter;
      end
      OP_COPY_B: begin
        r.kind = KIND_VERDICT;
        r.copy_a_valid = held_a_ok;
        r.copy_b_valid = good;
        r.load_ok = held_a_ok || good;
        if (held_a_ok && good) begin
          r.load_copy = hdr_counter > held_a_seq;
          r.save_target = held_a_seq > hdr_counter;
          newest = (held_a_seq >= hdr_counter) ? held_a_seq : hdr_counter;
        end else if (held_a_ok) begin
          r.save_target = 1'b1;
          newest = held_a_seq;
        end else if (good) begin
          r.load_copy = 1'b1;
          newest = hdr_counter;
        end
        r.next_counter = newest + 32'd1;
        due_outcomes.push_back(r);
      end
      default: begin
        r.kind = KIND_CRC;
        r.crc_value = run_crc;
        due_outcomes.push_back(r);
      end
    endcase
    clear_run();
  endfunction

  task automatic flag_error(input string what);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // result checker
  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.kind = kind_t'(m_tuser);
      got.copy_a_valid = m_tdata[0];
      got.copy_b_valid = m_tdata[1];
      got.load_ok = m_tdata[2];
      got.load_copy = m_tdata[3];
      got.save_target = m_tdata[4];
      got.next_counter = m_tdata[36:5];
      got.crc_value = m_tdata[68:37];
      if (due_outcomes.size() == 0) begin
        flag_error("result arrived with nothing expected");
      end else begin
        want = due_outcomes.pop_front();
        results_checked++;
        if (want.kind == KIND_VERDICT) verdicts_checked++;
        if (got.kind != want.kind)
          flag_error($sformatf("result_kind %0d, expected %0d", got.kind, want.kind));
        if (got.copy_a_valid != want.copy_a_valid)
          flag_error($sformatf("copy_a_valid %0d, expected %0d",
                               got.copy_a_valid, want.copy_a_valid));
        if (got.copy_b_valid != want.copy_b_valid)
          flag_error($sformatf("copy_b_valid %0d, expected %0d",
                               got.copy_b_valid, want.copy_b_valid));
        if (got.load_ok != want.load_ok)
          flag_error($sformatf("load_ok %0d, expected %0d", got.load_ok, want.load_ok));
        if (got.load_copy != want.load_copy)
          flag_error($sformatf("load_copy %0d, expected %0d", got.load_copy, want.load_copy));
        if (got.save_target != want.save_target)
          flag_error($sformatf("save_target %0d, expected %0d",
                               got.save_target, want.save_target));
        if (got.next_counter != want.next_counter)
          flag_error($sformatf("next_counter %h, expected %h",
                               got.next_counter, want.next_counter));
        if (got.crc_value != want.crc_value)
          flag_error($sformatf("crc_value %h, expected %h", got.crc_value, want.crc_value));
      end
    end
  end

  // receiver: random stalls, smooth stretches and one-off long hold-offs
  always @(posedge clk) begin
    if (rx_hold_tog != rx_hold_seen) begin
      rx_hold_seen <= rx_hold_tog;
      rx_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (rx_left > 0) begin
      rx_left <= rx_left - 1;
      m_tready <= (rx_left == 1);
    end else if (rx_smooth) begin
      m_tready <= 1'b1;
    end else if (m_tready && $urandom_range(0, 99) < 20) begin
      rx_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("watchdog: no request or result moved for %0d cycles", idle_cycles);
      $display("dual_copy_record_checker verification failed");
      $finish;
    end
  end

  task automatic tx_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_byte(input op_t op, input logic [7:0] b, input bit last, input bit rerr);
    int gap;
    gap = 0;
    if (!tx_smooth && $urandom_range(0, 99) < 25)
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, rerr, b};
    s_tuser <= op;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    scan_byte(op, b, last, rerr);
    if (op != OP_RSVD) bytes_accepted++;
  endtask

  task automatic send_stream(input op_t op, input logic [7:0] seq_bytes[$], input int bad_at,
                             input bit mixed);
    op_t cur;
    foreach (seq_bytes[i]) begin
      cur = op;
      if (mixed && i != seq_bytes.size() - 1) cur = op_t'($urandom_range(0, 2));
      send_byte(cur, seq_bytes[i], i == seq_bytes.size() - 1, i == bad_at);
    end
  endtask

  // ends a partly sent stream so that the next one starts at position zero
  task automatic close_stream();
    if (run_pos != 0) send_byte(OP_NEW, 8'($urandom), 1'b1, 1'b0);
  endtask

  task automatic wait_drain();
    tx_idle();
    while (due_outcomes.size() != 0) @(posedge clk);
    // a copy a end leaves no result; give it time to settle
    repeat (6) @(posedge clk);
  endtask

  task automatic apb_access(input reg_idx_t idx, input bit wr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= 3'(4 * idx);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (!wr && prdata != value)
      flag_error($sformatf("register %0d reads %h, expected %h", idx, prdata, value));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] magic, input logic [15:0] version);
    close_stream();
    wait_drain();
    apb_access(REG_MAGIC, 1'b1, magic);
    apb_access(REG_VERSION, 1'b1, {16'd0, version});
    want_magic = magic;
    want_version = version;
    apb_access(REG_MAGIC, 1'b0, magic);
    apb_access(REG_VERSION, 1'b0, {16'd0, version});
    settings_used++;
  endtask

  function automatic void make_record(output logic [7:0] rec[$], input logic [31:0] magic,
                                      input logic [15:0] version, input logic [15:0] len,
                                      input logic [31:0] seq);
    logic [31:0] c;
    rec = {};
    for (int i = 0; i < 4; i++) rec.push_back(magic[8*i +: 8]);
    for (int i = 0; i < 2; i++) rec.push_back(version[8*i +: 8]);
    for (int i = 0; i < 2; i++) rec.push_back(len[8*i +: 8]);
    for (int i = 0; i < 4; i++) rec.push_back(seq[8*i +: 8]);
    repeat (DATA_BYTES) rec.push_back(8'($urandom));
    c = CRC_INIT;
    foreach (rec[i]) c = crc_next(c, rec[i]);
    for (int i = 0; i < 4; i++) rec.push_back(c[8*i +: 8]);
  endfunction

  task automatic send_copy(input op_t op, input logic [31:0] seq, input flaw_t flaw);
    logic [7:0]  rec[$];
    logic [31:0] magic;
    logic [15:0] version;
    logic [15:0] len;
    int          bad_at;
    magic = want_magic;
    version = want_version;
    len = DATA_LEN;
    bad_at = -1;
    if (flaw == FLAW_MAGIC) magic[$urandom_range(0, 31)] ^= 1'b1;
    if (flaw == FLAW_VERSION) version[$urandom_range(0, 15)] ^= 1'b1;
    if (flaw == FLAW_LENGTH) len[$urandom_range(0, 15)] ^= 1'b1;
    make_record(rec, magic, version, len, seq);
    case (flaw)
      FLAW_CRC:   rec[$urandom_range(0, REC_BYTES - 1)] ^= 8'($urandom_range(1, 255));
      FLAW_READ:  bad_at = $urandom_range(0, REC_BYTES - 1);
      FLAW_SHORT: repeat ($urandom_range(1, REC_BYTES - 1)) void'(rec.pop_back());
      FLAW_LONG:  repeat ($urandom_range(1, 8)) rec.push_back(8'($urandom));
      default: ;
    endcase
    send_stream(op, rec, bad_at, flaw == FLAW_MIXED_OPS);
  endtask

  task automatic record_pair(input logic [31:0] seq_a, input flaw_t flaw_a,
                             input logic [31:0] seq_b, input flaw_t flaw_b);
    send_copy(OP_COPY_A, seq_a, flaw_a);
    send_copy(OP_COPY_B, seq_b, flaw_b);
  endtask

  task automatic send_new_record(input int len);
    logic [7:0] rec[$];
    repeat (len) rec.push_back(8'($urandom));
    send_stream(OP_NEW, rec, ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : -1,
                1'b0);
  endtask

  // valid copy b under the reset configuration, copy a never scanned
  task automatic test_scan_after_reset();
    send_copy(OP_COPY_B, 32'h0000_0007, FLAW_NONE);
    send_byte(OP_COPY_B, 8'hFF, 1'b1, 1'b0);
    wait_drain();
  endtask

  task automatic test_register_access();
    set_config(32'hFFFF_FFFF, 16'hFFFF);
    set_config(32'h0000_0000, 16'h0000);
    set_config(32'hA5C3_0F96, 16'h5A01);
  endtask

  task automatic test_reserved_and_short();
    send_byte(OP_RSVD, 8'hFF, 1'b1, 1'b1);
    send_byte(OP_NEW, 8'h00, 1'b1, 1'b0);
    send_byte(OP_NEW, 8'hFF, 1'b0, 1'b1);
    send_byte(OP_RSVD, 8'h3C, 1'b0, 1'b0);
    send_byte(OP_NEW, 8'h80, 1'b1, 1'b0);
    send_byte(OP_COPY_A, 8'h01, 1'b1, 1'b1);
    send_byte(OP_COPY_B, 8'h00, 1'b1, 1'b0);
    wait_drain();
  endtask

  task automatic test_record_pairs();
    record_pair(32'd10, FLAW_NONE, 32'd9, FLAW_NONE);      // a newer
    record_pair(32'd9, FLAW_NONE, 32'd10, FLAW_NONE);      // b newer
    record_pair(32'd55, FLAW_NONE, 32'd55, FLAW_NONE);     // tie goes to a
    record_pair(32'hFFFF_FFFF, FLAW_NONE, 32'd0, FLAW_NONE); // counter wraps
    // copy b alone reuses the copy a verdict held from the last pair
    send_copy(OP_COPY_B, 32'd4, FLAW_MAGIC);
    send_copy(OP_COPY_B, 32'd2, FLAW_LENGTH);
    send_copy(OP_COPY_B, 32'd7, FLAW_CRC);
    send_copy(OP_COPY_B, 32'd8, FLAW_SHORT);
    send_copy(OP_COPY_B, 32'd6, FLAW_LONG);
    send_copy(OP_COPY_B, 32'd5, FLAW_MIXED_OPS);
    record_pair(32'd3, FLAW_VERSION, 32'hFFFF_FFFF, FLAW_NONE);
    record_pair(32'd8, FLAW_READ, 32'd8, FLAW_READ);
    wait_drain();
  endtask

  task automatic test_new_records();
    send_new_record(CRC_SPAN);
    send_new_record(REC_BYTES + 20);
    send_new_record(1);
    wait_drain();
  endtask

  // receiver holds off while single-byte records keep coming; the block must stall its input
  task automatic test_backpressure();
    tx_smooth = 1'b1;
    rx_hold_tog <= ~rx_hold_tog;
    repeat (24) send_byte(OP_NEW, 8'($urandom), 1'b1, 1'b0);
    wait_drain();
    tx_smooth = 1'b0;
  endtask

  task automatic random_record_pair();
    logic [31:0] seq_a;
    logic [31:0] seq_b;
    flaw_t       flaw_a;
    flaw_t       flaw_b;
    seq_a = $urandom;
    case ($urandom_range(0, 4))
      0: seq_b = seq_a;
      1: seq_b = seq_a + 32'd1;
      2: seq_b = seq_a - 32'd1;
      3: seq_b = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : 32'd0;
      default: seq_b = $urandom;
    endcase
    flaw_a = ($urandom_range(0, 3) == 0) ? flaw_t'($urandom_range(1, 8)) : FLAW_NONE;
    flaw_b = ($urandom_range(0, 3) == 0) ? flaw_t'($urandom_range(1, 8)) : FLAW_NONE;
    if ($urandom_range(0, 9) != 0) send_copy(OP_COPY_A, seq_a, flaw_a);
    send_copy(OP_COPY_B, seq_b, flaw_b);
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 12))
      send_byte(op_t'($urandom_range(0, 3)), 8'($urandom), $urandom_range(0, 9) == 0,
                $urandom_range(0, 9) == 0);
    if ($urandom_range(0, 1) == 0) close_stream();
  endtask

  task automatic test_random_traffic();
    int start_bytes;
    int phase_start;
    int phase;
    int pick;
    start_bytes = bytes_accepted;
    phase_start = bytes_accepted;
    phase = 0;
    while (bytes_accepted - start_bytes < RANDOM_BYTES) begin
      if (bytes_accepted - phase_start >= PHASE_BYTES) begin
        phase++;
        phase_start = bytes_accepted;
        case (phase % 4)
          0: set_config(32'd0, 16'd0);
          1: set_config(32'hFFFF_FFFF, 16'hFFFF);
          2: set_config($urandom, 16'($urandom));
          default: set_config($urandom, 16'd0);
        endcase
        tx_smooth = (phase % 3 == 1);
        rx_smooth <= (phase % 3 == 2);
        if (phase % 2 == 0) rx_hold_tog <= ~rx_hold_tog;
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) random_record_pair();
      else if (pick < 85)
        send_new_record(($urandom_range(0, 4) == 0) ? $urandom_range(1, REC_BYTES + 8)
                                                    : $urandom_range(1, 16));
      else noise_burst();
    end
    close_stream();
  endtask

  initial begin
    error_count = 0;
    bytes_accepted = 0;
    results_checked = 0;
    verdicts_checked = 0;
    settings_used = 0;
    idle_cycles = 0;
    tx_smooth = 1'b0;
    rx_smooth = 1'b0;
    rx_hold_tog = 1'b0;
    rx_hold_seen = 1'b0;
    rx_left = 0;
    want_magic = '0;
    want_version = '0;
    held_a_ok = 1'b0;
    held_a_seq = '0;
    clear_run();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_scan_after_reset();
    test_register_access();
    test_reserved_and_short();
    test_record_pairs();
    test_new_records();
    test_backpressure();
    test_random_traffic();

    wait_drain();
    repeat (20) @(posedge clk);
    $display("run covered %0d bytes over %0d register settings", bytes_accepted, settings_used);
    $display("checked %0d results, %0d of them scan verdicts, %0d mismatches",
             results_checked, verdicts_checked, error_count);
    if (error_count == 0 && due_outcomes.size() == 0) begin
      $display("dual_copy_record_checker verification clean");
    end else begin
      if (due_outcomes.size() != 0) $display("%0d results never arrived", due_outcomes.size());
      $display("dual_copy_record_checker verification failed");
    end
    $finish;
  end

endmodule
